### src/sha1_pkg.sv
// shared types, constants and state encoding for the sha-1 stream hasher
package sha1_pkg;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        last_word;
    } t_out_item;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_BYTE  = 8'h80;
    localparam logic [5:0]  LENGTH_AT = 6'd56;
    localparam logic [2:0]  LAST_WORD = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LEN,
        S_ROUND,
        S_OUT
    } t_back_state;

endpackage

### src/sha1_front.sv
// input stage: two-entry queue of requests between the port and the engine
module sha1_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  sha1_pkg::t_in_item i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output sha1_pkg::t_in_item o_item
);
    import sha1_pkg::*;

    t_in_item   r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    // empty items with no end do nothing, drop them here
    assign o_ready = (r_cnt != 2'd2);
    assign push    = i_valid && o_ready && (i_item.has_byte || i_item.end_of_message);
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && i_ready;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

### src/sha1_back.sv
// engine: byte packing, padding, 80-round compression and digest output
module sha1_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  sha1_pkg::t_in_item i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output sha1_pkg::t_out_item o_item
);
    import sha1_pkg::*;

    t_back_state r_state, n_state;
    logic [31:0] r_w [16];
    logic [31:0] r_h [5];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic        r_end;    // message is being padded
    logic        r_mark;   // marker byte still to be written
    logic        r_tail;   // length is in, next compression is the last
    logic [2:0]  r_lenix;
    logic [6:0]  r_rnd;
    logic [2:0]  r_oix;

    logic        take_in;
    logic        put;
    logic [7:0]  put_byte;
    logic [31:0] f, k, t, wn, wcur;
    logic [1:0]  bsel;

    // control outputs
    always_comb begin
        o_ready  = 1'b0;
        put      = 1'b0;
        put_byte = 8'h00;
        unique case (r_state)
            S_IDLE: begin
                o_ready  = 1'b1;
                put      = i_valid && i_item.has_byte;
                put_byte = i_item.data_byte;
            end
            S_PAD: begin
                put      = 1'b1;
                put_byte = r_mark ? PAD_BYTE : 8'h00;
            end
            S_LEN: begin
                put      = 1'b1;
                put_byte = r_bits[{~r_lenix, 3'b111} -: 8];
            end
            default: ;
        endcase
    end
    assign take_in = (r_state == S_IDLE) && i_valid;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (take_in) begin
                    if (i_item.has_byte && r_fill == 6'd63) begin
                        n_state = S_ROUND;
                    end else if (i_item.end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (r_fill == 6'd63) begin
                    n_state = S_ROUND;
                end else if (r_fill == LENGTH_AT - 6'd1) begin
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                if (r_lenix == 3'd7) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                if (r_rnd == 7'd80) begin
                    if (!r_end) begin
                        n_state = S_IDLE;
                    end else if (r_tail) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_PAD;
                    end
                end
            end
            S_OUT: begin
                if (i_ready && r_oix == LAST_WORD) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // round datapath; schedule kept in place as a 16-word circular window
    assign wcur = r_w[r_rnd[3:0]];
    assign wn   = r_w[(r_rnd[3:0] + 4'd13)] ^ r_w[(r_rnd[3:0] + 4'd8)]
                  ^ r_w[(r_rnd[3:0] + 4'd2)] ^ wcur;
    always_comb begin
        if (r_rnd < 7'd20) begin
            f = (r_b & r_c) | (~r_b & r_d);
            k = K0;
        end else if (r_rnd < 7'd40) begin
            f = r_b ^ r_c ^ r_d;
            k = K1;
        end else if (r_rnd < 7'd60) begin
            f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k = K2;
        end else begin
            f = r_b ^ r_c ^ r_d;
            k = K3;
        end
    end
    assign t = {r_a[26:0], r_a[31:27]} + f + r_e + k
               + ((r_rnd < 7'd16) ? wcur : {wn[30:0], wn[31]});
    assign bsel = 2'd3 - r_fill[1:0];

    // block words: packed bytes, then overwritten by the schedule
    always_ff @(posedge i_clk) begin
        if (put) begin
            r_w[r_fill[5:2]] <= (r_fill[1:0] == 2'd0)
                ? {put_byte, 24'd0}
                : (r_w[r_fill[5:2]] | ({24'd0, put_byte} << {bsel, 3'b000}));
        end else if (r_state == S_ROUND && r_rnd < 7'd80 && r_rnd >= 7'd16) begin
            r_w[r_rnd[3:0]] <= {wn[30:0], wn[31]};
        end
    end

    // working variables
    always_ff @(posedge i_clk) begin
        if (n_state == S_ROUND && r_state != S_ROUND) begin
            r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3]; r_e <= r_h[4];
        end else if (r_state == S_ROUND && r_rnd < 7'd80) begin
            r_e <= r_d; r_d <= r_c; r_c <= {r_b[1:0], r_b[31:2]};
            r_b <= r_a; r_a <= t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_h[0] <= H0; r_h[1] <= H1; r_h[2] <= H2; r_h[3] <= H3; r_h[4] <= H4;
            r_fill  <= 6'd0;
            r_bits  <= 64'd0;
            r_end   <= 1'b0;
            r_mark  <= 1'b0;
            r_tail  <= 1'b0;
            r_lenix <= 3'd0;
            r_rnd   <= 7'd0;
            r_oix   <= 3'd0;
        end else begin
            r_state <= n_state;
            if (put) begin
                r_fill <= r_fill + 6'd1;
            end
            if (take_in) begin
                if (i_item.has_byte) begin
                    r_bits <= r_bits + 64'd8;
                end
                r_end  <= i_item.end_of_message;
                r_mark <= i_item.end_of_message;
            end else if (r_state == S_PAD) begin
                r_mark <= 1'b0;
            end
            if (r_state == S_LEN) begin
                r_lenix <= r_lenix + 3'd1;
                if (r_lenix == 3'd7) begin
                    r_tail <= 1'b1;
                end
            end
            if (n_state == S_ROUND && r_state != S_ROUND) begin
                r_rnd <= 7'd0;
            end else if (r_state == S_ROUND && r_rnd < 7'd80) begin
                r_rnd <= r_rnd + 7'd1;
            end
            if (r_state == S_ROUND && r_rnd == 7'd80) begin
                r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c; r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end else if (r_state == S_OUT && i_ready && r_oix == LAST_WORD) begin
                r_h[0] <= H0; r_h[1] <= H1; r_h[2] <= H2; r_h[3] <= H3;
                r_h[4] <= H4;
            end
            if (r_state == S_OUT && i_ready) begin
                if (r_oix == LAST_WORD) begin
                    // fill and length index have already wrapped to zero
                    r_oix  <= 3'd0;
                    r_bits <= 64'd0;
                    r_end  <= 1'b0;
                    r_tail <= 1'b0;
                end else begin
                    r_oix <= r_oix + 3'd1;
                end
            end
        end
    end

    assign o_valid = (r_state == S_OUT);
    assign o_item  = '{digest_word: r_h[r_oix],
                       word_number: r_oix,
                       last_word:   (r_oix == LAST_WORD)};
endmodule

### src/sha1_stream_hash.sv
// top level of the sha-1 stream hasher
// sha-1 over a byte stream: one byte per request, big-endian packing into 64-byte blocks,
// 80 rounds per block at one round per cycle, then the chaining update,
// so a byte is packed as it is taken, and input stalls while each full block compresses;
// the end of a message adds padding at one byte a cycle, one or two compressions
// and five digest words, after which the state is back at its initial values.
// a two-entry queue in front lets the sender keep going while the engine works.
module sha1_stream_hash (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sha1_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output sha1_pkg::t_out_item o_data
);
    import sha1_pkg::*;

    logic     q_valid, q_ready;
    t_in_item q_item;

    // front queue
    sha1_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_data),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    // hashing engine
    sha1_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_item  (q_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_data)
    );
endmodule

### sim/sha1_stream_hash_tb.sv
// testbench for the sha-1 stream hasher: directed table, random messages, digest predictor
`timescale 1ns / 1ps

module sha1_stream_hash_tb;
    import sha1_pkg::*;

    localparam int CYCLE_LIMIT = 50_000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_data;

    sha1_stream_hash dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    // predictor state, mirrors the hasher
    logic [31:0] chain_h [5];
    logic [31:0] blk_words [16];
    logic [5:0]  blk_fill;
    logic [63:0] msg_bits;

    t_out_item   digest_q [$];
    int          n_errors = 0;
    int          send_idle_pct;
    int          recv_idle_pct;
    longint      cycle_count = 0;

    // directed table: byte, data, end
    typedef struct {
        bit       hb;
        bit [7:0] db;
        bit       eom;
    } t_row;

    function automatic logic [31:0] rol(logic [31:0] v, int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    task automatic hash_reset();
        chain_h[0] = H0; chain_h[1] = H1; chain_h[2] = H2;
        chain_h[3] = H3; chain_h[4] = H4;
        foreach (blk_words[i]) blk_words[i] = '0;
        blk_fill = '0;
        msg_bits = '0;
    endtask

    task automatic compress_block();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int r = 0; r < 16; r++) w[r] = blk_words[r];
        for (int r = 16; r < 80; r++) w[r] = rol(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
        for (int r = 0; r < 80; r++) begin
            if (r < 20) begin
                f = (b & c) | (~b & d); k = K0;
            end else if (r < 40) begin
                f = b ^ c ^ d; k = K1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d); k = K2;
            end else begin
                f = b ^ c ^ d; k = K3;
            end
            t = rol(a, 5) + f + e + k + w[r];
            e = d; d = c; c = rol(b, 30); b = a; a = t;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d; chain_h[4] += e;
    endtask

    task automatic pack_byte(logic [7:0] bv);
        int w;
        int sh;
        w  = int'(blk_fill[5:2]);
        sh = (3 - int'(blk_fill[1:0])) * 8;
        if (blk_fill[1:0] == 2'd0) blk_words[w] = '0;
        blk_words[w] |= 32'(bv) << sh;
        blk_fill = blk_fill + 6'd1;
        if (blk_fill == 6'd0) compress_block();
    endtask

    // take one request, queue the five digest words at end of message
    task automatic predict_digest(t_in_item it);
        logic [63:0] bits;
        t_out_item   o;
        if (it.has_byte) begin
            pack_byte(it.data_byte);
            msg_bits += 64'd8;
        end
        if (!it.end_of_message) return;
        bits = msg_bits;
        pack_byte(PAD_BYTE);
        while (blk_fill != LENGTH_AT) pack_byte(8'h00);
        for (int i = 0; i < 8; i++) pack_byte(bits[63 - 8*i -: 8]);
        for (int i = 0; i < 5; i++) begin
            o.digest_word    = chain_h[i];
            o.word_number    = 3'(i);
            o.last_word      = (3'(i) == LAST_WORD);
            digest_q.push_back(o);
        end
        hash_reset();
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sha1_stream_hash_tb: done, errors");
            $finish;
        end
    end

    // receiver side: random stalls, compare with oldest expected word
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (digest_q.size() == 0) begin
                    $error("unexpected digest word %h", o_data.digest_word);
                    n_errors++;
                end else begin
                    want = digest_q.pop_front();
                    if (o_data.digest_word !== want.digest_word) begin
                        $error("digest_word exp %h got %h", want.digest_word,
                               o_data.digest_word);
                        n_errors++;
                    end
                    if (o_data.word_number !== want.word_number) begin
                        $error("word_number exp %0d got %0d", want.word_number,
                               o_data.word_number);
                        n_errors++;
                    end
                    if (o_data.last_word !== want.last_word) begin
                        $error("last_word exp %0b got %0b", want.last_word,
                               o_data.last_word);
                        n_errors++;
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // drive one request and wait for its acceptance; valid stays up for the next one
    task automatic send_request(t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_digest(it);
    endtask

    // random message: mostly bytes, sometimes idle items, ends with a digest
    task automatic random_message(int len);
        t_in_item it;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(19) == 0) begin
                it = '{has_byte: 1'b0, data_byte: 8'($urandom), end_of_message: 1'b0};
                send_request(it);
            end
            it.has_byte       = 1'b1;
            it.data_byte      = 8'($urandom);
            it.end_of_message = (i == len - 1);
            send_request(it);
        end
        if (len == 0) begin
            it = '{has_byte: 1'b0, data_byte: 8'($urandom), end_of_message: 1'b1};
            send_request(it);
        end
    endtask

    initial begin
        t_row      dir_rows [$];
        t_in_item  it;
        int        len;
        int        sent;
        int        table_errors;
        table_errors  = 0;
        send_idle_pct = 34;
        recv_idle_pct = 69;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        hash_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty message straight after reset, known digest da39a3ee...
        send_request('{has_byte: 1'b0, data_byte: 8'h00, end_of_message: 1'b1});
        if (digest_q.size() != 5 || digest_q[0].digest_word != 32'hDA39A3EE) begin
            $error("digest_word exp %h got %h", 32'hDA39A3EE,
                   (digest_q.size() != 0) ? digest_q[0].digest_word : 32'h0);
            table_errors++;
        end

        // idle item with no byte, then "abc" with end on the last byte,
        // extremes of data_byte, byte+end on a lone byte
        dir_rows = '{
            '{1'b0, 8'hFF, 1'b0},
            '{1'b1, 8'h61, 1'b0}, '{1'b1, 8'h62, 1'b0}, '{1'b1, 8'h63, 1'b1},
            '{1'b1, 8'h00, 1'b0}, '{1'b1, 8'hFF, 1'b0}, '{1'b0, 8'h55, 1'b1},
            '{1'b1, 8'hFF, 1'b1},
            '{1'b1, 8'h00, 1'b1},
            '{1'b1, 8'hAA, 1'b0}, '{1'b0, 8'h00, 1'b0}, '{1'b1, 8'h55, 1'b1}
        };
        foreach (dir_rows[i]) begin
            it.has_byte       = dir_rows[i].hb;
            it.data_byte      = dir_rows[i].db;
            it.end_of_message = dir_rows[i].eom;
            send_request(it);
        end
        // padding boundaries: 55, 56, 64 bytes
        random_message(55);
        random_message(56);
        random_message(64);

        // random phases: receiver idles more, then sender, then neither
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 69 : 0;
            recv_idle_pct = (ph == 0) ? 69 : (ph == 1) ? 34 : 0;
            sent = 0;
            while (sent < 12) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(8);
                random_message(len);
                sent += len + 1;
            end
        end
        i_valid <= 1'b0;

        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (n_errors == 0 && table_errors == 0 && digest_q.size() == 0) begin
            $display("sha1_stream_hash_tb: done, clean");
        end else begin
            $display("sha1_stream_hash_tb: done, errors");
        end
        $finish;
    end

endmodule

### sha1_stream_hash.f
src/sha1_pkg.sv
src/sha1_front.sv
src/sha1_back.sv
src/sha1_stream_hash.sv
sim/sha1_stream_hash_tb.sv
